// ===== rtl/hsbrgb_pkg.sv =====
// Shared types, constants and divide helpers for the HSB to RGB converter.
// No dependencies; used by every module of the converter.
package hsbrgb_pkg;

   localparam int HUE_W  = 9;
   localparam int PCT_W  = 7;
   localparam int CHAN_W = 8;
   localparam int FRAC_W = 6;
   localparam int SEC_W  = 3;
   localparam int QCNT_W = 4;

   localparam int SECTOR_DEG = 60;
   localparam int PCT_MAX    = 100;
   localparam int CHAN_MAX   = 255;
   localparam int SECTORS    = 6;
   localparam int HUE_STEPS  = 8;

   localparam int RECIP_SHIFT = 20;
   localparam int DIV60_MUL   = 17477;
   localparam int DIV100_MUL  = 10486;

   localparam int SF_W   = 13;
   localparam int NUM_W  = 14;
   localparam int WIDE_W = 15;

   localparam logic [SEC_W-1:0] SEC_RED     = 3'd0;
   localparam logic [SEC_W-1:0] SEC_YELLOW  = 3'd1;
   localparam logic [SEC_W-1:0] SEC_GREEN   = 3'd2;
   localparam logic [SEC_W-1:0] SEC_CYAN    = 3'd3;
   localparam logic [SEC_W-1:0] SEC_BLUE    = 3'd4;
   localparam logic [SEC_W-1:0] SEC_MAGENTA = 3'd5;

   typedef struct packed {
      logic [SEC_W-1:0]  sector;
      logic [FRAC_W-1:0] frac;
      logic [PCT_W-1:0]  sat;
      logic [PCT_W-1:0]  bri;
   } angle_type;

   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [PCT_W-1:0] bri;
      logic [SF_W-1:0]  sf;
      logic [SF_W-1:0]  sft;
      logic [NUM_W-1:0] pn;
   } prod_type;

   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [PCT_W-1:0] bri;
      logic [PCT_W-1:0] qa;
      logic [PCT_W-1:0] ta;
      logic [NUM_W-1:0] pn;
   } quot_type;

   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [PCT_W-1:0] bri;
      logic [NUM_W-1:0] qn;
      logic [NUM_W-1:0] tn;
      logic [NUM_W-1:0] pn;
   } num_type;

   typedef struct packed {
      logic [SEC_W-1:0] sector;
      logic [PCT_W-1:0] bri;
      logic [PCT_W-1:0] p;
      logic [PCT_W-1:0] q;
      logic [PCT_W-1:0] t;
   } level_type;

   typedef struct packed {
      logic [WIDE_W-1:0] r;
      logic [WIDE_W-1:0] g;
      logic [WIDE_W-1:0] b;
   } wide_type;

   function automatic logic [PCT_W-1:0] div60(input logic [SF_W-1:0] x);
      logic [SF_W+WIDE_W-1:0] prod;
      prod = (SF_W+WIDE_W)'(x) * (SF_W+WIDE_W)'(DIV60_MUL);
      return prod[RECIP_SHIFT +: PCT_W];
   endfunction

   function automatic logic [CHAN_W-1:0] div100(input logic [WIDE_W-1:0] x);
      logic [WIDE_W+NUM_W-1:0] prod;
      prod = (WIDE_W+NUM_W)'(x) * (WIDE_W+NUM_W)'(DIV100_MUL);
      return prod[RECIP_SHIFT +: CHAN_W];
   endfunction

endpackage

// ===== rtl/hsbrgb_sector.sv =====
// First pipeline stage: clamps saturation and brightness, splits hue into sector and offset.
// Depends on hsbrgb_pkg.
module hsbrgb_sector (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [hsbrgb_pkg::HUE_W-1:0]   hue,
   input  logic [hsbrgb_pkg::PCT_W-1:0]   sat,
   input  logic [hsbrgb_pkg::PCT_W-1:0]   bri,
   output logic                           out_valid,
   input  logic                           out_ready,
   output hsbrgb_pkg::angle_type          out_data
);

   logic                              vld_ff;
   hsbrgb_pkg::angle_type             data_ff;
   hsbrgb_pkg::angle_type             data_in;
   logic [hsbrgb_pkg::QCNT_W-1:0]     qcnt;
   logic [hsbrgb_pkg::HUE_W-1:0]      base;

   always_comb begin
      qcnt = '0;
      for (int k = 1; k <= hsbrgb_pkg::HUE_STEPS; k++) begin
         if (hue >= hsbrgb_pkg::HUE_W'(k * hsbrgb_pkg::SECTOR_DEG)) begin
            qcnt = qcnt + 1'b1;
         end
      end
      base = hsbrgb_pkg::HUE_W'(qcnt) * hsbrgb_pkg::HUE_W'(hsbrgb_pkg::SECTOR_DEG);
      data_in.frac = hsbrgb_pkg::FRAC_W'(hue - base);
      if (qcnt >= hsbrgb_pkg::QCNT_W'(hsbrgb_pkg::SECTORS)) begin
         data_in.sector = hsbrgb_pkg::SEC_W'(qcnt - hsbrgb_pkg::QCNT_W'(hsbrgb_pkg::SECTORS));
      end else begin
         data_in.sector = hsbrgb_pkg::SEC_W'(qcnt);
      end
      data_in.sat = (sat > hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX)) ?
                    hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX) : sat;
      data_in.bri = (bri > hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX)) ?
                    hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX) : bri;
   end

   assign in_ready  = !vld_ff || out_ready;
   assign out_valid = vld_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else if (in_ready) begin
         vld_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   a_sector_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff |-> (data_ff.frac < hsbrgb_pkg::FRAC_W'(hsbrgb_pkg::SECTOR_DEG)) &&
                 (data_ff.sector < hsbrgb_pkg::SEC_W'(hsbrgb_pkg::SECTORS)) &&
                 (data_ff.sat <= hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX)))
      else $error("sector stage out of range");

endmodule

// ===== rtl/hsbrgb_level.sv =====
// Pipeline stages two to five: forms the p, q and t levels with products and
// reciprocal divides by 60 and 100. Depends on hsbrgb_pkg.
module hsbrgb_level (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  hsbrgb_pkg::angle_type   in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output hsbrgb_pkg::level_type   out_data
);

   logic                    vld2_ff, vld3_ff, vld4_ff, vld5_ff;
   logic                    rdy2, rdy3, rdy4, rdy5;
   hsbrgb_pkg::prod_type    s2_ff, s2_in;
   hsbrgb_pkg::quot_type    s3_ff, s3_in;
   hsbrgb_pkg::num_type     s4_ff, s4_in;
   hsbrgb_pkg::level_type   s5_ff, s5_in;
   logic [hsbrgb_pkg::CHAN_W-1:0] p_div, q_div, t_div;

   assign rdy5     = !vld5_ff || out_ready;
   assign rdy4     = !vld4_ff || rdy5;
   assign rdy3     = !vld3_ff || rdy4;
   assign rdy2     = !vld2_ff || rdy3;
   assign in_ready = rdy2;

   always_comb begin
      s2_in.sector = in_data.sector;
      s2_in.bri    = in_data.bri;
      s2_in.sf     = hsbrgb_pkg::SF_W'(in_data.sat) * hsbrgb_pkg::SF_W'(in_data.frac);
      s2_in.sft    = hsbrgb_pkg::SF_W'(in_data.sat) *
                     hsbrgb_pkg::SF_W'(hsbrgb_pkg::FRAC_W'(hsbrgb_pkg::SECTOR_DEG) - in_data.frac);
      s2_in.pn     = hsbrgb_pkg::NUM_W'(in_data.bri) *
                     hsbrgb_pkg::NUM_W'(hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX) - in_data.sat);
   end

   always_comb begin
      s3_in.sector = s2_ff.sector;
      s3_in.bri    = s2_ff.bri;
      s3_in.qa     = hsbrgb_pkg::div60(s2_ff.sf);
      s3_in.ta     = hsbrgb_pkg::div60(s2_ff.sft);
      s3_in.pn     = s2_ff.pn;
   end

   always_comb begin
      s4_in.sector = s3_ff.sector;
      s4_in.bri    = s3_ff.bri;
      s4_in.qn     = hsbrgb_pkg::NUM_W'(s3_ff.bri) *
                     hsbrgb_pkg::NUM_W'(hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX) - s3_ff.qa);
      s4_in.tn     = hsbrgb_pkg::NUM_W'(s3_ff.bri) *
                     hsbrgb_pkg::NUM_W'(hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX) - s3_ff.ta);
      s4_in.pn     = s3_ff.pn;
   end

   always_comb begin
      p_div        = hsbrgb_pkg::div100(hsbrgb_pkg::WIDE_W'(s4_ff.pn));
      q_div        = hsbrgb_pkg::div100(hsbrgb_pkg::WIDE_W'(s4_ff.qn));
      t_div        = hsbrgb_pkg::div100(hsbrgb_pkg::WIDE_W'(s4_ff.tn));
      s5_in.sector = s4_ff.sector;
      s5_in.bri    = s4_ff.bri;
      s5_in.p      = p_div[hsbrgb_pkg::PCT_W-1:0];
      s5_in.q      = q_div[hsbrgb_pkg::PCT_W-1:0];
      s5_in.t      = t_div[hsbrgb_pkg::PCT_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld2_ff <= 1'b0;
         vld3_ff <= 1'b0;
         vld4_ff <= 1'b0;
         vld5_ff <= 1'b0;
      end else begin
         if (rdy2) begin
            vld2_ff <= in_valid;
         end
         if (rdy3) begin
            vld3_ff <= vld2_ff;
         end
         if (rdy4) begin
            vld4_ff <= vld3_ff;
         end
         if (rdy5) begin
            vld5_ff <= vld4_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && in_valid) begin
         s2_ff <= s2_in;
      end
      if (rdy3 && vld2_ff) begin
         s3_ff <= s3_in;
      end
      if (rdy4 && vld3_ff) begin
         s4_ff <= s4_in;
      end
      if (rdy5 && vld4_ff) begin
         s5_ff <= s5_in;
      end
   end

   assign out_valid = vld5_ff;
   assign out_data  = s5_ff;

   a_level_order: assert property (@(posedge clock) disable iff (reset)
      vld5_ff |-> (s5_ff.p <= s5_ff.q) && (s5_ff.p <= s5_ff.t) &&
                  (s5_ff.q <= s5_ff.bri) && (s5_ff.t <= s5_ff.bri))
      else $error("levels out of order");

   a_level_hold: assert property (@(posedge clock) disable iff (reset)
      (vld5_ff && !out_ready) |=> vld5_ff && $stable(s5_ff))
      else $error("level stage lost a held transaction");

endmodule

// ===== rtl/hsbrgb_scale.sv =====
// Pipeline stages six and seven: routes levels to channels by sector and scales
// each by 255/100. Depends on hsbrgb_pkg.
module hsbrgb_scale (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              in_valid,
   output logic                              in_ready,
   input  hsbrgb_pkg::level_type             in_data,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [hsbrgb_pkg::CHAN_W-1:0]     red,
   output logic [hsbrgb_pkg::CHAN_W-1:0]     green,
   output logic [hsbrgb_pkg::CHAN_W-1:0]     blue
);

   logic                               vld6_ff, vld7_ff;
   logic                               rdy6, rdy7;
   hsbrgb_pkg::wide_type               s6_ff, s6_in;
   logic [hsbrgb_pkg::PCT_W-1:0]       lr, lg, lb;
   logic [hsbrgb_pkg::CHAN_W-1:0]      red_ff, green_ff, blue_ff;

   assign rdy7     = !vld7_ff || out_ready;
   assign rdy6     = !vld6_ff || rdy7;
   assign in_ready = rdy6;

   always_comb begin
      case (in_data.sector)
         hsbrgb_pkg::SEC_RED: begin
            lr = in_data.bri; lg = in_data.t;   lb = in_data.p;
         end
         hsbrgb_pkg::SEC_YELLOW: begin
            lr = in_data.q;   lg = in_data.bri; lb = in_data.p;
         end
         hsbrgb_pkg::SEC_GREEN: begin
            lr = in_data.p;   lg = in_data.bri; lb = in_data.t;
         end
         hsbrgb_pkg::SEC_CYAN: begin
            lr = in_data.p;   lg = in_data.q;   lb = in_data.bri;
         end
         hsbrgb_pkg::SEC_BLUE: begin
            lr = in_data.t;   lg = in_data.p;   lb = in_data.bri;
         end
         default: begin
            lr = in_data.bri; lg = in_data.p;   lb = in_data.q;
         end
      endcase
      s6_in.r = hsbrgb_pkg::WIDE_W'({lr, hsbrgb_pkg::CHAN_W'(0)}) - hsbrgb_pkg::WIDE_W'(lr);
      s6_in.g = hsbrgb_pkg::WIDE_W'({lg, hsbrgb_pkg::CHAN_W'(0)}) - hsbrgb_pkg::WIDE_W'(lg);
      s6_in.b = hsbrgb_pkg::WIDE_W'({lb, hsbrgb_pkg::CHAN_W'(0)}) - hsbrgb_pkg::WIDE_W'(lb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld6_ff <= 1'b0;
         vld7_ff <= 1'b0;
      end else begin
         if (rdy6) begin
            vld6_ff <= in_valid;
         end
         if (rdy7) begin
            vld7_ff <= vld6_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy6 && in_valid) begin
         s6_ff <= s6_in;
      end
      if (rdy7 && vld6_ff) begin
         red_ff   <= hsbrgb_pkg::div100(s6_ff.r);
         green_ff <= hsbrgb_pkg::div100(s6_ff.g);
         blue_ff  <= hsbrgb_pkg::div100(s6_ff.b);
      end
   end

   assign out_valid = vld7_ff;
   assign red       = red_ff;
   assign green     = green_ff;
   assign blue      = blue_ff;

   a_scale_bound: assert property (@(posedge clock) disable iff (reset)
      vld6_ff |-> (s6_ff.r <= hsbrgb_pkg::WIDE_W'(hsbrgb_pkg::PCT_MAX * hsbrgb_pkg::CHAN_MAX)) &&
                  (s6_ff.g <= hsbrgb_pkg::WIDE_W'(hsbrgb_pkg::PCT_MAX * hsbrgb_pkg::CHAN_MAX)) &&
                  (s6_ff.b <= hsbrgb_pkg::WIDE_W'(hsbrgb_pkg::PCT_MAX * hsbrgb_pkg::CHAN_MAX)))
      else $error("scaled channel above full scale");

endmodule

// ===== rtl/hsb_to_rgb_converter.sv =====
// HSB to RGB converter, top level.
// Depends on hsbrgb_pkg, hsbrgb_sector, hsbrgb_level and hsbrgb_scale.
//
// Usage:
//   The req_ channel carries one colour per transaction: hue in degrees,
//   saturation and brightness in percent. Values above range are folded
//   (hue taken modulo 360) or clamped to 100. The rsp_ channel returns the
//   8-bit red, green and blue for each request, in order, one per request.
//   The result is held in an output register until it is taken.
//   Throughput is one transaction per cycle while rsp_stall is low.
//   The depth is set by the chain of constant-reciprocal multiplies
//   (divide by 60, then by 100 for the levels, then by 100 for scaling),
//   each followed by a register, seven stages in all.
//   Every stage advances when it is empty or the stage after it advances,
//   so bubbles close up while rsp_stall is high; req_stall rises only when
//   all seven stages hold data and the output is stalled.
//   Reset (synchronous, active high) empties the pipeline; the block keeps
//   no other state.
module hsb_to_rgb_converter (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [hsbrgb_pkg::HUE_W-1:0]      req_hue,
   input  logic [hsbrgb_pkg::PCT_W-1:0]      req_saturation,
   input  logic [hsbrgb_pkg::PCT_W-1:0]      req_brightness,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [hsbrgb_pkg::CHAN_W-1:0]     rsp_red,
   output logic [hsbrgb_pkg::CHAN_W-1:0]     rsp_green,
   output logic [hsbrgb_pkg::CHAN_W-1:0]     rsp_blue
);

   logic                    sec_ready;
   logic                    ang_valid, ang_ready;
   hsbrgb_pkg::angle_type   ang_data;
   logic                    lvl_valid, lvl_ready;
   hsbrgb_pkg::level_type   lvl_data;

   assign req_stall = !sec_ready;

   hsbrgb_sector u_sector (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (sec_ready),
      .hue       (req_hue),
      .sat       (req_saturation),
      .bri       (req_brightness),
      .out_valid (ang_valid),
      .out_ready (ang_ready),
      .out_data  (ang_data)
   );

   hsbrgb_level u_level (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (ang_valid),
      .in_ready  (ang_ready),
      .in_data   (ang_data),
      .out_valid (lvl_valid),
      .out_ready (lvl_ready),
      .out_data  (lvl_data)
   );

   hsbrgb_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lvl_valid),
      .in_ready  (lvl_ready),
      .in_data   (lvl_data),
      .out_valid (rsp_valid),
      .out_ready (!rsp_stall),
      .red       (rsp_red),
      .green     (rsp_green),
      .blue      (rsp_blue)
   );

endmodule

// ===== tb/sv/hsb_to_rgb_converter_tb.sv =====
// Self-checking testbench for hsb_to_rgb_converter: a queue-fed driver, a monitor
// with an integer HSB to RGB predictor, and random idling on both channels.
// Depends on hsbrgb_pkg and the hsb_to_rgb_converter RTL.
module hsb_to_rgb_converter_tb;

   localparam int WATCHDOG_LIMIT = 500;
   localparam int TAIL_CYCLES    = 20;
   localparam int RANDOM_ITEMS   = 1600;

   typedef struct {
      logic [hsbrgb_pkg::HUE_W-1:0] hue;
      logic [hsbrgb_pkg::PCT_W-1:0] sat;
      logic [hsbrgb_pkg::PCT_W-1:0] bri;
      bit                           drain;
   } color_req_type;

   typedef struct {
      logic [hsbrgb_pkg::CHAN_W-1:0] red;
      logic [hsbrgb_pkg::CHAN_W-1:0] green;
      logic [hsbrgb_pkg::CHAN_W-1:0] blue;
   } rgb_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [hsbrgb_pkg::HUE_W-1:0]  req_hue = '0;
   logic [hsbrgb_pkg::PCT_W-1:0]  req_saturation = '0;
   logic [hsbrgb_pkg::PCT_W-1:0]  req_brightness = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [hsbrgb_pkg::CHAN_W-1:0] rsp_red;
   logic [hsbrgb_pkg::CHAN_W-1:0] rsp_green;
   logic [hsbrgb_pkg::CHAN_W-1:0] rsp_blue;

   color_req_type pending_colors[$];
   rgb_type       rgb_expected[$];

   bit req_taken;
   int errors;
   int idle_cycles;
   int converted;
   int checked;
   int clamped;
   int greys;
   int burst_left;
   int gap_left;
   int stall_mode;
   int stall_mode_left;
   int stall_hold;

   hsb_to_rgb_converter u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_hue        (req_hue),
      .req_saturation (req_saturation),
      .req_brightness (req_brightness),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue)
   );

   always #5 clock = ~clock;

   function automatic rgb_type convert_hsb(input logic [hsbrgb_pkg::HUE_W-1:0] hue,
                                           input logic [hsbrgb_pkg::PCT_W-1:0] sat_in,
                                           input logic [hsbrgb_pkg::PCT_W-1:0] bri_in);
      int unsigned                  s, v, f, p, q, t, lv_r, lv_g, lv_b;
      logic [hsbrgb_pkg::SEC_W-1:0] sec;
      rgb_type                      c;
      s = (sat_in > hsbrgb_pkg::PCT_MAX) ? hsbrgb_pkg::PCT_MAX : sat_in;
      v = (bri_in > hsbrgb_pkg::PCT_MAX) ? hsbrgb_pkg::PCT_MAX : bri_in;
      sec = hsbrgb_pkg::SEC_W'((hue / hsbrgb_pkg::SECTOR_DEG) % hsbrgb_pkg::SECTORS);
      f = hue % hsbrgb_pkg::SECTOR_DEG;
      p = v * (hsbrgb_pkg::PCT_MAX - s) / hsbrgb_pkg::PCT_MAX;
      q = v * (hsbrgb_pkg::PCT_MAX - (s * f) / hsbrgb_pkg::SECTOR_DEG) / hsbrgb_pkg::PCT_MAX;
      t = v * (hsbrgb_pkg::PCT_MAX - (s * (hsbrgb_pkg::SECTOR_DEG - f)) /
               hsbrgb_pkg::SECTOR_DEG) / hsbrgb_pkg::PCT_MAX;
      case (sec)
         hsbrgb_pkg::SEC_RED: begin
            lv_r = v; lv_g = t; lv_b = p;
         end
         hsbrgb_pkg::SEC_YELLOW: begin
            lv_r = q; lv_g = v; lv_b = p;
         end
         hsbrgb_pkg::SEC_GREEN: begin
            lv_r = p; lv_g = v; lv_b = t;
         end
         hsbrgb_pkg::SEC_CYAN: begin
            lv_r = p; lv_g = q; lv_b = v;
         end
         hsbrgb_pkg::SEC_BLUE: begin
            lv_r = t; lv_g = p; lv_b = v;
         end
         default: begin
            lv_r = v; lv_g = p; lv_b = q;
         end
      endcase
      c.red   = hsbrgb_pkg::CHAN_W'(lv_r * hsbrgb_pkg::CHAN_MAX / hsbrgb_pkg::PCT_MAX);
      c.green = hsbrgb_pkg::CHAN_W'(lv_g * hsbrgb_pkg::CHAN_MAX / hsbrgb_pkg::PCT_MAX);
      c.blue  = hsbrgb_pkg::CHAN_W'(lv_b * hsbrgb_pkg::CHAN_MAX / hsbrgb_pkg::PCT_MAX);
      return c;
   endfunction

   function automatic logic [hsbrgb_pkg::PCT_W-1:0] pick_percent();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return hsbrgb_pkg::PCT_W'($urandom_range(hsbrgb_pkg::PCT_MAX + 1, 127));
      else if (r == 1)
         return '0;
      else if (r == 2)
         return hsbrgb_pkg::PCT_W'(hsbrgb_pkg::PCT_MAX);
      return hsbrgb_pkg::PCT_W'($urandom_range(0, hsbrgb_pkg::PCT_MAX));
   endfunction

   task automatic add_color(input int hue, input int sat, input int bri, input bit drain);
      color_req_type item;
      item.hue   = hsbrgb_pkg::HUE_W'(hue);
      item.sat   = hsbrgb_pkg::PCT_W'(sat);
      item.bri   = hsbrgb_pkg::PCT_W'(bri);
      item.drain = drain;
      pending_colors.push_back(item);
   endtask

   task automatic check_channel(input string chan,
                                input logic [hsbrgb_pkg::CHAN_W-1:0] want,
                                input logic [hsbrgb_pkg::CHAN_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch: expected %0d, actual %0d", $time, chan, want, got);
      end
   endtask

   // driver: bursts of transactions separated by random gaps
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (gap_left > 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_colors.size() == 0 ||
                         (pending_colors[0].drain && rgb_expected.size() != 0)) begin
               req_valid <= 1'b0;
            end else begin
               color_req_type item;
               item = pending_colors.pop_front();
               req_valid      <= 1'b1;
               req_hue        <= item.hue;
               req_saturation <= item.sat;
               req_brightness <= item.bri;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end

         // receiver stall pattern: free-running, random, or long holds
         if (stall_mode_left <= 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_mode_left = $urandom_range(50, 300);
            stall_hold = 0;
         end
         stall_mode_left--;
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 9) < 4);
            default: begin
               if (stall_hold <= 0) begin
                  stall_hold = rsp_stall ? $urandom_range(1, 6) : $urandom_range(5, 20);
                  rsp_stall <= ~rsp_stall;
               end else begin
                  stall_hold--;
               end
            end
         endcase
      end
   end

   // monitor: predict on accepted requests, compare accepted responses
   always @(posedge clock) begin
      req_taken = 1'b0;
      if (!reset) begin
         idle_cycles++;
         if (req_valid && !req_stall) begin
            req_taken = 1'b1;
            idle_cycles = 0;
            converted++;
            if (req_saturation > hsbrgb_pkg::PCT_MAX || req_brightness > hsbrgb_pkg::PCT_MAX ||
                req_hue >= hsbrgb_pkg::SECTORS * hsbrgb_pkg::SECTOR_DEG)
               clamped++;
            if (req_saturation == 0)
               greys++;
            rgb_expected.push_back(convert_hsb(req_hue, req_saturation, req_brightness));
         end
         if (rsp_valid && !rsp_stall) begin
            idle_cycles = 0;
            if (rgb_expected.size() == 0) begin
               errors++;
               $display("%0t: unexpected result r=%0d g=%0d b=%0d", $time,
                        rsp_red, rsp_green, rsp_blue);
            end else begin
               rgb_type want;
               want = rgb_expected.pop_front();
               checked++;
               check_channel("red", want.red, rsp_red);
               check_channel("green", want.green, rsp_green);
               check_channel("blue", want.blue, rsp_blue);
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding", $time,
                     rgb_expected.size());
            $display("Verification failed");
            $finish;
         end
      end
   end

   initial begin
      burst_left = 1;
      add_color(0, 100, 100, 0);
      add_color(60, 100, 100, 0);
      add_color(120, 100, 100, 0);
      add_color(180, 100, 100, 0);
      add_color(240, 100, 100, 0);
      add_color(300, 100, 100, 0);
      add_color(59, 100, 100, 0);
      add_color(359, 100, 100, 0);
      add_color(30, 50, 75, 0);
      add_color(90, 80, 60, 0);
      add_color(150, 40, 90, 0);
      add_color(210, 70, 30, 0);
      add_color(270, 60, 50, 0);
      add_color(330, 100, 20, 0);
      add_color(0, 0, 100, 0);
      add_color(200, 0, 55, 0);
      add_color(0, 100, 0, 0);
      add_color(0, 0, 0, 0);
      add_color(360, 100, 100, 0);
      add_color(419, 101, 101, 0);
      add_color(511, 127, 127, 0);
      add_color(45, 127, 100, 0);
      add_color(100, 50, 127, 0);
      add_color(256, 85, 42, 0);
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         int hue;
         hue = ($urandom_range(0, 4) == 0) ? $urandom_range(360, 511)
                                           : $urandom_range(0, 359);
         add_color(hue, pick_percent(), pick_percent(), (i % 400) == 0);
      end

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      wait (pending_colors.size() == 0 && !req_valid);
      wait (rgb_expected.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Converted %0d colors, %0d with folded hue or clamped percent, %0d greys",
               converted, clamped, greys);
      $display("Checked %0d results, %0d mismatches", checked, errors);
      if (errors == 0 && rgb_expected.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
